// ----- design/vslc_pkg.sv -----
// Package for the video sync line capture unit: register map, state codes,
// result codes and the structs shared by the configuration, core and top level.
// No dependencies.
package vslc_pkg;

  localparam int unsigned LINE_WORDS = 512;
  localparam int unsigned MAX_LINES  = 256;
  localparam int unsigned BUF_WORDS  = LINE_WORDS * MAX_LINES;

  localparam int unsigned ADDR_W    = 17;
  localparam int unsigned NEXT_W    = ADDR_W + 1;
  localparam int unsigned LINE_CNT_W = 10;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_MIN   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_MAX   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_MIN  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_MAX  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_LINE = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_LINES  = 4'd7;

  localparam logic [1:0] EDGE_NONE    = 2'd0;
  localparam logic [1:0] EDGE_FALL    = 2'd1;
  localparam logic [1:0] EDGE_RISE    = 2'd2;

  localparam logic [1:0] CLASS_NONE   = 2'd0;
  localparam logic [1:0] CLASS_LINE   = 2'd1;
  localparam logic [1:0] CLASS_FRAME  = 2'd2;

  localparam logic [1:0] STATUS_STOPPED = 2'd0;
  localparam logic [1:0] STATUS_ARMED   = 2'd1;
  localparam logic [1:0] STATUS_LOCKED  = 2'd2;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_START  = 1'b1;

  typedef enum logic [2:0] {
    RUN_STOPPED = 3'b001,
    RUN_ARMED   = 3'b010,
    RUN_LOCKED  = 3'b100
  } run_state_e;

  typedef struct packed {
    logic [7:0]  low_thr;
    logic [7:0]  high_thr;
    logic [15:0] line_min;
    logic [15:0] line_max;
    logic [15:0] frame_min;
    logic [15:0] frame_max;
    logic [7:0]  first_line;
    logic [8:0]  num_lines;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        edge_res;
    logic [15:0]       period;
    logic [1:0]        pulse_class;
    logic              line_start;
    logic [ADDR_W-1:0] line_address;
    logic              capture_stopped;
    logic [1:0]        run_status;
  } res_t;

endpackage

// ----- design/vslc_cfg_regs.sv -----
// Configuration register bank of the video sync line capture unit.
// Depends on vslc_pkg for the register map and the cfg_t struct.
module vslc_cfg_regs import vslc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output logic                 cfg_ready_o,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LOW_THR:    cfg_d.low_thr    = cfg_data_i[7:0];
        REG_HIGH_THR:   cfg_d.high_thr   = cfg_data_i[7:0];
        REG_LINE_MIN:   cfg_d.line_min   = cfg_data_i;
        REG_LINE_MAX:   cfg_d.line_max   = cfg_data_i;
        REG_FRAME_MIN:  cfg_d.frame_min  = cfg_data_i;
        REG_FRAME_MAX:  cfg_d.frame_max  = cfg_data_i;
        REG_FIRST_LINE: cfg_d.first_line = cfg_data_i[7:0];
        REG_NUM_LINES:  cfg_d.num_lines  = cfg_data_i[8:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_thr    <= 8'd10;
      cfg_q.high_thr   <= 8'd42;
      cfg_q.line_min   <= 16'd62;
      cfg_q.line_max   <= 16'd66;
      cfg_q.frame_min  <= 16'd30;
      cfg_q.frame_max  <= 16'd34;
      cfg_q.first_line <= 8'd17;
      cfg_q.num_lines  <= 9'd240;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- design/vslc_sync_core.sv -----
// Sync separator and line counter core: hysteresis comparator, period
// measurement, pulse classification and frame-buffer addressing.
// Depends on vslc_pkg for state codes, cfg_t and res_t.
module vslc_sync_core import vslc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic        mode_i,
  input  logic [7:0]  sample_i,
  input  logic [15:0] timestamp_i,
  input  cfg_t        cfg_i,
  output res_t        res_o
);

  run_state_e            run_q, run_d;
  logic                  wait_high_q, wait_high_d;
  logic [15:0]           prev_ts_q, prev_ts_d;
  logic                  sync_pend_q, sync_pend_d;
  logic [LINE_CNT_W-1:0] line_cnt_q, line_cnt_d;
  logic [ADDR_W-1:0]     wr_ptr_q, wr_ptr_d;

  logic [15:0]           period;
  logic [LINE_CNT_W-1:0] line_inc;
  logic [LINE_CNT_W-1:0] win_end;
  logic [NEXT_W-1:0]     ptr_next;
  logic                  in_line_win;
  logic                  in_frame_win;

  assign period       = timestamp_i - prev_ts_q;
  assign line_inc     = line_cnt_q + LINE_CNT_W'(1);
  assign win_end      = LINE_CNT_W'(cfg_i.first_line) + LINE_CNT_W'(cfg_i.num_lines);
  assign ptr_next     = {1'b0, wr_ptr_q} + NEXT_W'(LINE_WORDS);
  assign in_line_win  = (period > cfg_i.line_min) && (period < cfg_i.line_max);
  assign in_frame_win = (period > cfg_i.frame_min) && (period < cfg_i.frame_max);

  always_comb begin
    run_d       = run_q;
    wait_high_d = wait_high_q;
    prev_ts_d   = prev_ts_q;
    sync_pend_d = sync_pend_q;
    line_cnt_d  = line_cnt_q;
    wr_ptr_d    = wr_ptr_q;
    res_o       = '0;

    if (mode_i == MODE_START) begin
      run_d       = RUN_ARMED;
      wait_high_d = 1'b0;
      sync_pend_d = 1'b0;
    end else if (run_q != RUN_STOPPED) begin
      if (!wait_high_q) begin
        if (sample_i < cfg_i.low_thr) begin
          res_o.edge_res = EDGE_FALL;
          res_o.period   = period;
          if (in_line_win && run_q == RUN_LOCKED) begin
            res_o.pulse_class = CLASS_LINE;
            if (sync_pend_q) begin
              sync_pend_d = 1'b0;
              line_cnt_d  = '0;
              wr_ptr_d    = '0;
            end else begin
              line_cnt_d = line_inc;
              if (line_inc >= LINE_CNT_W'(cfg_i.first_line) && line_inc < win_end) begin
                res_o.line_start   = 1'b1;
                res_o.line_address = wr_ptr_q;
                if (ptr_next >= NEXT_W'(BUF_WORDS)) begin
                  wr_ptr_d = '0;
                end else begin
                  wr_ptr_d = ptr_next[ADDR_W-1:0];
                end
              end else if (line_inc >= win_end) begin
                run_d                 = RUN_STOPPED;
                res_o.capture_stopped = 1'b1;
              end
            end
          end else if (in_frame_win) begin
            res_o.pulse_class = CLASS_FRAME;
            sync_pend_d       = 1'b1;
            run_d             = RUN_LOCKED;
          end
          prev_ts_d   = timestamp_i;
          wait_high_d = 1'b1;
        end
      end else if (sample_i > cfg_i.high_thr) begin
        res_o.edge_res = EDGE_RISE;
        wait_high_d    = 1'b0;
      end
    end

    case (run_d)
      RUN_STOPPED: res_o.run_status = STATUS_STOPPED;
      RUN_ARMED:   res_o.run_status = STATUS_ARMED;
      RUN_LOCKED:  res_o.run_status = STATUS_LOCKED;
      default:     res_o.run_status = STATUS_STOPPED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= RUN_STOPPED;
      wait_high_q <= 1'b0;
      prev_ts_q   <= '0;
      sync_pend_q <= 1'b0;
      line_cnt_q  <= '0;
      wr_ptr_q    <= '0;
    end else if (fire_i) begin
      run_q       <= run_d;
      wait_high_q <= wait_high_d;
      prev_ts_q   <= prev_ts_d;
      sync_pend_q <= sync_pend_d;
      line_cnt_q  <= line_cnt_d;
      wr_ptr_q    <= wr_ptr_d;
    end
  end

endmodule

// ----- design/video_sync_line_capture_unit.sv -----
// Top level of the video sync line capture unit: input register, core and
// result register. Depends on vslc_pkg, vslc_cfg_regs and vslc_sync_core.
//
// Usage: each input word is either a sync-channel sample with its microsecond
// timestamp (mode 0) or a start command (mode 1). Every input word yields
// exactly one result word, in order. A word is taken when in_valid_i is high
// and in_stall_o is low; a result is taken when out_valid_o is high and
// out_stall_i is low. Configuration writes arrive on their own channel
// (cfg_valid_i, cfg_index_i, cfg_data_i) and are always ready; indices past
// the register list are ignored. Write configuration only while idle.
// A result word goes from the input register through the core to the result
// register and waits while the receiver stalls. One word is taken every cycle
// while the receiver does not stall, since the input and result registers are
// separated by a single pass through the comparator and counter logic.
// Reset stops the capture, clears all counters and loads the default register
// values. When the receiver stalls, the result register holds and the input
// register fills; only then does in_stall_o rise.
module video_sync_line_capture_unit import vslc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 mode_i,
  input  logic [7:0]           sample_i,
  input  logic [15:0]          timestamp_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           edge_res_o,
  output logic [15:0]          period_o,
  output logic [1:0]           pulse_class_o,
  output logic                 line_start_o,
  output logic [ADDR_W-1:0]    line_address_o,
  output logic                 capture_stopped_o,
  output logic [1:0]           run_status_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  cfg_t        cfg;
  res_t        res;
  res_t        out_q;
  logic        out_valid_q;
  logic        s1_valid_q;
  logic        s1_mode_q;
  logic [7:0]  s1_sample_q;
  logic [15:0] s1_ts_q;
  logic        s1_go;
  logic        fire;
  logic        in_accept;

  assign s1_go      = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && s1_go;
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept  = in_valid_i && !in_stall_o;

  vslc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  vslc_sync_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .mode_i      (s1_mode_q),
    .sample_i    (s1_sample_q),
    .timestamp_i (s1_ts_q),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_go) begin
        out_valid_q <= s1_valid_q;
      end
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_mode_q   <= mode_i;
      s1_sample_q <= sample_i;
      s1_ts_q     <= timestamp_i;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign edge_res_o        = out_q.edge_res;
  assign period_o          = out_q.period;
  assign pulse_class_o     = out_q.pulse_class;
  assign line_start_o      = out_q.line_start;
  assign line_address_o    = out_q.line_address;
  assign capture_stopped_o = out_q.capture_stopped;
  assign run_status_o      = out_q.run_status;

  a_start_is_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.line_start |-> out_q.pulse_class == CLASS_LINE)
    else $error("Line start reported without a line period.");

  a_stop_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.capture_stopped |-> out_q.run_status == STATUS_STOPPED)
    else $error("Capture stop reported while the run status is not stopped.");

  a_class_needs_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.pulse_class != CLASS_NONE |-> out_q.edge_res == EDGE_FALL)
    else $error("Pulse class given without a falling edge.");

  a_result_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("Result appeared without a word in the input register.");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the video sync line capture unit: directed words, then
// random frames of sync pulses, each result checked against a given word or a line capture predictor.
// Depends on vslc_pkg and video_sync_line_capture_unit.
module testbench;
  import vslc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 4'd15;

  typedef struct {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;
    logic                 known;
    res_t                 want;
    logic                 mode;
    logic [7:0]           smp;
    logic [15:0]          ts;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 mode_i;
  logic [7:0]           sample_i;
  logic [15:0]          timestamp_i;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [1:0]           edge_res_o;
  logic [15:0]          period_o;
  logic [1:0]           pulse_class_o;
  logic                 line_start_o;
  logic [ADDR_W-1:0]    line_address_o;
  logic                 capture_stopped_o;
  logic [1:0]           run_status_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  cfg_t                  sh_cfg;
  logic [1:0]            ps_run;
  logic                  ps_wait_high;
  logic [15:0]           ps_prev_ts;
  logic                  ps_sync_pending;
  logic [LINE_CNT_W-1:0] ps_line_cnt;
  logic [ADDR_W-1:0]     ps_wr_ptr;

  res_t        expected_words[$];
  stim_row_t   dir_rows[$];
  res_t        seen_word;
  logic [15:0] line_clock;
  int          mismatches = 0;
  int          results_checked = 0;
  int          words_sent = 0;
  int          settings_loaded = 0;
  int          send_gap_odds = 3;
  int          recv_stall_odds = 3;
  int          stall_left = 0;
  bit          settle_phase = 1'b0;

  video_sync_line_capture_unit u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic res_t predict_capture(input logic m, input logic [7:0] smp,
                                           input logic [15:0] ts);
    res_t                  r;
    logic [LINE_CNT_W:0]   line_end;
    logic [NEXT_W-1:0]     next_ptr;
    r = '0;
    if (m == MODE_START) begin
      ps_run = STATUS_ARMED;
      ps_wait_high = 1'b0;
      ps_sync_pending = 1'b0;
    end else if (ps_run != STATUS_STOPPED) begin
      if (!ps_wait_high) begin
        if (smp < sh_cfg.low_thr) begin
          r.edge_res = EDGE_FALL;
          r.period = ts - ps_prev_ts;
          if (r.period > sh_cfg.line_min && r.period < sh_cfg.line_max &&
              ps_run == STATUS_LOCKED) begin
            r.pulse_class = CLASS_LINE;
            if (ps_sync_pending) begin
              ps_sync_pending = 1'b0;
              ps_line_cnt = '0;
              ps_wr_ptr = '0;
            end else begin
              line_end = (LINE_CNT_W+1)'(sh_cfg.first_line) +
                         (LINE_CNT_W+1)'(sh_cfg.num_lines);
              ps_line_cnt = ps_line_cnt + 1'b1;
              if (ps_line_cnt >= sh_cfg.first_line && ps_line_cnt < line_end) begin
                r.line_start = 1'b1;
                r.line_address = ps_wr_ptr;
                next_ptr = NEXT_W'(ps_wr_ptr) + NEXT_W'(LINE_WORDS);
                if (next_ptr >= NEXT_W'(BUF_WORDS)) begin
                  next_ptr = '0;
                end
                ps_wr_ptr = next_ptr[ADDR_W-1:0];
              end else if (ps_line_cnt >= line_end) begin
                ps_run = STATUS_STOPPED;
                r.capture_stopped = 1'b1;
              end
            end
          end else if (r.period > sh_cfg.frame_min && r.period < sh_cfg.frame_max) begin
            r.pulse_class = CLASS_FRAME;
            ps_sync_pending = 1'b1;
            ps_run = STATUS_LOCKED;
          end
          ps_prev_ts = ts;
          ps_wait_high = 1'b1;
        end
      end else if (smp > sh_cfg.high_thr) begin
        r.edge_res = EDGE_RISE;
        ps_wait_high = 1'b0;
      end
    end
    r.run_status = ps_run;
    return r;
  endfunction

  function automatic res_t mk_res(input logic [1:0] e, input logic [15:0] p,
                                  input logic [1:0] c, input logic st,
                                  input logic [ADDR_W-1:0] a, input logic sp,
                                  input logic [1:0] rs);
    return {e, p, c, st, a, sp, rs};
  endfunction

  function automatic stim_row_t word_row(input logic known, input res_t want,
                                         input logic m, input logic [7:0] s,
                                         input logic [15:0] ts);
    stim_row_t row;
    row = '{is_cfg: 1'b0, idx: REG_LOW_THR, data: '0, known: known, want: want,
            mode: m, smp: s, ts: ts};
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DAT_W-1:0] data);
    stim_row_t row;
    row = '{is_cfg: 1'b1, idx: idx, data: data, known: 1'b0, want: '0,
            mode: MODE_SAMPLE, smp: '0, ts: '0};
    return row;
  endfunction

  function automatic logic [15:0] window_period(input int unsigned lo, input int unsigned hi);
    if (hi > lo + 1) begin
      return 16'($urandom_range(lo + 1, hi - 1));
    end
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] below_low();
    if (sh_cfg.low_thr == 8'd0) begin
      return 8'd0;
    end
    return 8'($urandom_range(0, sh_cfg.low_thr - 1));
  endfunction

  function automatic logic [7:0] above_high();
    if (sh_cfg.high_thr == 8'd255) begin
      return 8'd255;
    end
    return 8'($urandom_range(sh_cfg.high_thr + 1, 255));
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen_word = {edge_res_o, period_o, pulse_class_o, line_start_o, line_address_o,
                     capture_stopped_o, run_status_o};
        results_checked++;
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t ns: result word expected none, actual 0x%0h", $time, seen_word);
        end else begin
          check_field("edge_res", expected_words[0].edge_res, seen_word.edge_res);
          check_field("period", expected_words[0].period, seen_word.period);
          check_field("pulse_class", expected_words[0].pulse_class, seen_word.pulse_class);
          check_field("line_start", expected_words[0].line_start, seen_word.line_start);
          check_field("line_address", expected_words[0].line_address,
                      seen_word.line_address);
          check_field("capture_stopped", expected_words[0].capture_stopped,
                      seen_word.capture_stopped);
          check_field("run_status", expected_words[0].run_status, seen_word.run_status);
          void'(expected_words.pop_front());
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (recv_stall_odds != 0 && $urandom_range(0, recv_stall_odds) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_row(input logic known, input res_t want, input logic m,
                          input logic [7:0] s, input logic [15:0] ts);
    res_t predicted;
    if (send_gap_odds != 0 && $urandom_range(0, send_gap_odds) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= m;
    sample_i    <= s;
    timestamp_i <= ts;
    do @(posedge clk_i); while (in_stall_o);
    predicted = predict_capture(m, s, ts);
    expected_words.push_back(known ? want : predicted);
    words_sent++;
  endtask

  task automatic send_word(input logic m, input logic [7:0] s, input logic [15:0] ts);
    send_row(1'b0, '0, m, s, ts);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_LOW_THR:    sh_cfg.low_thr    = data[7:0];
      REG_HIGH_THR:   sh_cfg.high_thr   = data[7:0];
      REG_LINE_MIN:   sh_cfg.line_min   = data;
      REG_LINE_MAX:   sh_cfg.line_max   = data;
      REG_FRAME_MIN:  sh_cfg.frame_min  = data;
      REG_FRAME_MAX:  sh_cfg.frame_max  = data;
      REG_FIRST_LINE: sh_cfg.first_line = data[7:0];
      REG_NUM_LINES:  sh_cfg.num_lines  = data[8:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [7:0] lo, input logic [7:0] hi,
                             input logic [15:0] lmin, input logic [15:0] lmax,
                             input logic [15:0] fmin, input logic [15:0] fmax,
                             input logic [7:0] fl, input logic [8:0] nl);
    drain();
    write_reg(REG_LOW_THR, {8'($urandom), lo});
    write_reg(REG_HIGH_THR, {8'($urandom), hi});
    write_reg(REG_LINE_MIN, lmin);
    write_reg(REG_LINE_MAX, lmax);
    write_reg(REG_FRAME_MIN, fmin);
    write_reg(REG_FRAME_MAX, fmax);
    write_reg(REG_FIRST_LINE, {8'($urandom), fl});
    write_reg(REG_NUM_LINES, {7'($urandom), nl});
    write_reg(4'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), 16'($urandom));
    cfg_valid_i <= 1'b0;
    settings_loaded++;
  endtask

  task automatic sync_pulse(input logic [15:0] gap);
    line_clock += gap;
    send_word(MODE_SAMPLE, below_low(), line_clock);
    if ($urandom_range(0, 3) == 0) begin
      send_word(MODE_SAMPLE, 8'($urandom), 16'($urandom));
    end
    send_word(MODE_SAMPLE, above_high(), 16'($urandom));
  endtask

  task automatic capture_frame();
    int lines;
    lines = sh_cfg.first_line + sh_cfg.num_lines + 2;
    if (lines > 14) begin
      lines = $urandom_range(3, 14);
    end
    send_word(MODE_START, 8'($urandom), 16'($urandom));
    repeat ($urandom_range(0, 2)) send_word(MODE_SAMPLE, 8'($urandom), 16'($urandom));
    repeat ($urandom_range(1, 3)) sync_pulse(window_period(sh_cfg.frame_min, sh_cfg.frame_max));
    repeat (lines) begin
      if ($urandom_range(0, 9) == 0) begin
        sync_pulse(16'($urandom));
      end else begin
        sync_pulse(window_period(sh_cfg.line_min, sh_cfg.line_max));
      end
    end
  endtask

  task automatic random_phase();
    logic [7:0]  lo, hi, fl;
    logic [15:0] lmin, lmax, fmin, fmax;
    logic [8:0]  nl;
    case ($urandom_range(0, 9))
      0:       lo = 8'd0;
      1:       lo = 8'd255;
      default: lo = 8'($urandom_range(1, 200));
    endcase
    case ($urandom_range(0, 9))
      0:       hi = 8'd0;
      1:       hi = 8'd255;
      default: hi = 8'($urandom_range(20, 254));
    endcase
    if ($urandom_range(0, 7) == 0) begin
      lmin = 16'd0;
      lmax = 16'hFFFF;
    end else begin
      lmin = 16'($urandom_range(40, 200));
      lmax = lmin + 16'($urandom_range(2, 12));
    end
    case ($urandom_range(0, 7))
      0: begin
        fmin = lmin;
        fmax = lmax;
      end
      1: begin
        fmin = 16'd0;
        fmax = 16'hFFFF;
      end
      default: begin
        fmin = 16'($urandom_range(5, 35));
        fmax = fmin + 16'($urandom_range(2, 8));
      end
    endcase
    fl = ($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(0, 6));
    case ($urandom_range(0, 9))
      0:       nl = 9'd0;
      1:       nl = 9'd511;
      default: nl = 9'($urandom_range(1, 6));
    endcase
    load_config(lo, hi, lmin, lmax, fmin, fmax, fl, nl);
    if (!settle_phase) begin
      send_gap_odds = $urandom_range(0, 6);
      recv_stall_odds = $urandom_range(0, 6);
    end
    line_clock = 16'($urandom);
    repeat ($urandom_range(1, 3)) begin
      capture_frame();
      repeat ($urandom_range(0, 4)) begin
        send_word(($urandom_range(0, 7) == 0) ? MODE_START : MODE_SAMPLE,
                  8'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    mode_i      = MODE_SAMPLE;
    sample_i    = '0;
    timestamp_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_LOW_THR;
    cfg_data_i  = '0;
    sh_cfg = '{low_thr: 8'd10, high_thr: 8'd42, line_min: 16'd62, line_max: 16'd66,
               frame_min: 16'd30, frame_max: 16'd34, first_line: 8'd17,
               num_lines: 9'd240};
    ps_run          = STATUS_STOPPED;
    ps_wait_high    = 1'b0;
    ps_prev_ts      = '0;
    ps_sync_pending = 1'b0;
    ps_line_cnt     = '0;
    ps_wr_ptr       = '0;

    dir_rows.push_back(word_row(1'b1, mk_res(EDGE_NONE, 16'h0, CLASS_NONE, 1'b0, '0, 1'b0,
                       STATUS_STOPPED), MODE_SAMPLE, 8'd0, 16'h0000));
    dir_rows.push_back(word_row(1'b1, mk_res(EDGE_NONE, 16'h0, CLASS_NONE, 1'b0, '0, 1'b0,
                       STATUS_STOPPED), MODE_SAMPLE, 8'd255, 16'hFFFF));
    dir_rows.push_back(word_row(1'b1, mk_res(EDGE_NONE, 16'h0, CLASS_NONE, 1'b0, '0, 1'b0,
                       STATUS_ARMED), MODE_START, 8'd255, 16'hFFFF));
    dir_rows.push_back(word_row(1'b1, mk_res(EDGE_NONE, 16'h0, CLASS_NONE, 1'b0, '0, 1'b0,
                       STATUS_ARMED), MODE_SAMPLE, 8'd10, 16'd5));
    dir_rows.push_back(word_row(1'b1, mk_res(EDGE_FALL, 16'd32, CLASS_FRAME, 1'b0, '0, 1'b0,
                       STATUS_LOCKED), MODE_SAMPLE, 8'd9, 16'd32));
    dir_rows.push_back(word_row(1'b1, mk_res(EDGE_NONE, 16'h0, CLASS_NONE, 1'b0, '0, 1'b0,
                       STATUS_LOCKED), MODE_SAMPLE, 8'd42, 16'd40));
    dir_rows.push_back(word_row(1'b1, mk_res(EDGE_RISE, 16'h0, CLASS_NONE, 1'b0, '0, 1'b0,
                       STATUS_LOCKED), MODE_SAMPLE, 8'd43, 16'd41));
    dir_rows.push_back(word_row(1'b1, mk_res(EDGE_FALL, 16'd64, CLASS_LINE, 1'b0, '0, 1'b0,
                       STATUS_LOCKED), MODE_SAMPLE, 8'd0, 16'd96));
    dir_rows.push_back(word_row(1'b0, '0, MODE_SAMPLE, 8'd255, 16'd100));
    dir_rows.push_back(word_row(1'b0, '0, MODE_SAMPLE, 8'd0, 16'd160));
    dir_rows.push_back(word_row(1'b1, mk_res(EDGE_NONE, 16'h0, CLASS_NONE, 1'b0, '0, 1'b0,
                       STATUS_ARMED), MODE_START, 8'd0, 16'd0));
    dir_rows.push_back(word_row(1'b0, '0, MODE_SAMPLE, 8'd200, 16'd170));
    dir_rows.push_back(word_row(1'b1, mk_res(EDGE_FALL, 16'd64, CLASS_NONE, 1'b0, '0, 1'b0,
                       STATUS_ARMED), MODE_SAMPLE, 8'd3, 16'd224));
    dir_rows.push_back(word_row(1'b0, '0, MODE_SAMPLE, 8'd255, 16'd230));
    dir_rows.push_back(word_row(1'b1, mk_res(EDGE_FALL, 16'd0, CLASS_NONE, 1'b0, '0, 1'b0,
                       STATUS_ARMED), MODE_SAMPLE, 8'd0, 16'd224));
    dir_rows.push_back(word_row(1'b0, '0, MODE_SAMPLE, 8'd128, 16'd300));
    dir_rows.push_back(word_row(1'b0, '0, MODE_SAMPLE, 8'd1, 16'hFFF0));
    dir_rows.push_back(word_row(1'b0, '0, MODE_SAMPLE, 8'd255, 16'hFFF8));
    dir_rows.push_back(word_row(1'b1, mk_res(EDGE_FALL, 16'h001F, CLASS_FRAME, 1'b0, '0,
                       1'b0, STATUS_LOCKED), MODE_SAMPLE, 8'd0, 16'h000F));
    dir_rows.push_back(cfg_row(REG_FIRST_LINE, 16'd1));
    dir_rows.push_back(cfg_row(REG_NUM_LINES, 16'd1));
    dir_rows.push_back(word_row(1'b0, '0, MODE_SAMPLE, 8'd255, 16'h0020));
    dir_rows.push_back(word_row(1'b0, '0, MODE_SAMPLE, 8'd0, 16'h004F));
    dir_rows.push_back(word_row(1'b0, '0, MODE_SAMPLE, 8'd255, 16'h0060));
    dir_rows.push_back(word_row(1'b1, mk_res(EDGE_FALL, 16'd64, CLASS_LINE, 1'b1, '0, 1'b0,
                       STATUS_LOCKED), MODE_SAMPLE, 8'd0, 16'h008F));
    dir_rows.push_back(word_row(1'b0, '0, MODE_SAMPLE, 8'd255, 16'h00A0));
    dir_rows.push_back(word_row(1'b1, mk_res(EDGE_FALL, 16'd64, CLASS_LINE, 1'b0, '0, 1'b1,
                       STATUS_STOPPED), MODE_SAMPLE, 8'd0, 16'h00CF));
    dir_rows.push_back(word_row(1'b1, mk_res(EDGE_NONE, 16'h0, CLASS_NONE, 1'b0, '0, 1'b0,
                       STATUS_STOPPED), MODE_SAMPLE, 8'd0, 16'h0100));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
        if (i + 1 == dir_rows.size() || !dir_rows[i + 1].is_cfg) begin
          cfg_valid_i <= 1'b0;
        end
      end else begin
        send_row(dir_rows[i].known, dir_rows[i].want, dir_rows[i].mode,
                 dir_rows[i].smp, dir_rows[i].ts);
      end
    end

    while (words_sent < 450) begin
      if (words_sent >= 380) begin
        settle_phase = 1'b1;
        send_gap_odds = 0;
        recv_stall_odds = 0;
      end
      random_phase();
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("Summary: %0d words sent under %0d register settings, with random frames.",
             words_sent, settings_loaded);
    $display("Summary: %0d result words checked, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
